FILE: design/hashed_signature_lookup_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hashed signature lookup table
// Shared property templates used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HASHED_SIGNATURE_LOOKUP_TABLE_ASSERT_SVH
`define HASHED_SIGNATURE_LOOKUP_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hsl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hsl assertion failed");

`endif

FILE: design/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Types, codes and sizing constants of the hashed signature lookup table.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;

    localparam int SIG_W    = 64;
    localparam int NODE_W   = 31;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 9;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd256;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;

    localparam logic signed [VAL_W-1:0] NO_VALUE = -32'sd1;

    typedef struct packed {
        logic              func;
        logic [SIG_W-1:0]  signature;
        logic [NODE_W-1:0] node_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] found_value;
    } t_rsp;

    // Write strobes from the sequencer to the table storage.
    typedef struct packed {
        logic fill_we;
        logic ent_we;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FILL,
        S_KEY,
        S_CMP,
        S_FINISH
    } t_state;

endpackage

FILE: design/hsl_div.sv
// ----------------------------------------------------------------------------
// hsl_div
// Serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module hsl_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [hsl_pkg::SIG_W-1:0] i_dividend,
    input  logic [hsl_pkg::CFG_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [hsl_pkg::CFG_W-1:0] o_rem
);

    localparam int CW = $clog2(hsl_pkg::SIG_W);

    logic                      r_run;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [hsl_pkg::SIG_W-1:0] r_dvd;
    logic [hsl_pkg::CFG_W-1:0] r_div;
    logic [hsl_pkg::CFG_W-1:0] r_rem;

    logic [hsl_pkg::CFG_W:0]   trial;
    logic [hsl_pkg::CFG_W-1:0] n_rem;

    // Shift in the next dividend bit; subtract the divisor when it fits.
    always_comb begin
        trial = {r_rem, r_dvd[hsl_pkg::SIG_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = hsl_pkg::CFG_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = hsl_pkg::CFG_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(hsl_pkg::SIG_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[hsl_pkg::SIG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: design/hsl_table.sv
// ----------------------------------------------------------------------------
// hsl_table
// Bucket fill counts and entry storage, one registered read port each.
// ----------------------------------------------------------------------------
module hsl_table #(
    parameter int BUCKETS = hsl_pkg::BUCKETS_DEF,
    parameter int WAYS    = hsl_pkg::WAYS_DEF,
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int FW     = $clog2(WAYS + 1)
) (
    input  logic                       i_clk,
    input  hsl_pkg::t_mem_ctl          i_ctl,
    input  logic [BW-1:0]              i_bucket,
    input  logic [WW-1:0]              i_way,
    input  logic [FW-1:0]              i_fill_wdata,
    input  logic [hsl_pkg::SIG_W-1:0]  i_key,
    input  logic [hsl_pkg::NODE_W-1:0] i_node,
    output logic [FW-1:0]              o_fill,
    output logic [hsl_pkg::SIG_W-1:0]  o_key,
    output logic [hsl_pkg::NODE_W-1:0] o_node
);

    localparam int FILL_D = 1 << BW;
    localparam int ENT_D  = 1 << (BW + WW);

    logic [FW-1:0]              fill_mem [FILL_D];
    logic [hsl_pkg::SIG_W-1:0]  key_mem  [ENT_D];
    logic [hsl_pkg::NODE_W-1:0] node_mem [ENT_D];

    logic [FW-1:0]              r_fill;
    logic [hsl_pkg::SIG_W-1:0]  r_key;
    logic [hsl_pkg::NODE_W-1:0] r_node;

    logic [BW+WW-1:0] ent_addr;

    assign ent_addr = {i_bucket, i_way};

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill_we) begin
            fill_mem[i_bucket] <= i_fill_wdata;
        end
        r_fill <= fill_mem[i_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ent_we) begin
            key_mem[ent_addr]  <= i_key;
            node_mem[ent_addr] <= i_node;
        end
        r_key  <= key_mem[ent_addr];
        r_node <= node_mem[ent_addr];
    end

    assign o_fill = r_fill;
    assign o_key  = r_key;
    assign o_node = r_node;

endmodule

FILE: design/hsl_ctrl.sv
// ----------------------------------------------------------------------------
// hsl_ctrl
// Request sequencer: clear sweep, remainder, bucket scan and result.
// ----------------------------------------------------------------------------
module hsl_ctrl #(
    parameter int BUCKETS = hsl_pkg::BUCKETS_DEF,
    parameter int WAYS    = hsl_pkg::WAYS_DEF,
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int FW     = $clog2(WAYS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  hsl_pkg::t_req              i_req,
    input  logic                       i_cfg_we,
    input  logic [hsl_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_div_done,
    input  logic [hsl_pkg::CFG_W-1:0]  i_div_rem,
    input  logic [FW-1:0]              i_fill,
    input  logic [hsl_pkg::SIG_W-1:0]  i_key,
    input  logic [hsl_pkg::NODE_W-1:0] i_node,
    output logic                       o_div_start,
    output logic [hsl_pkg::CFG_W-1:0]  o_divisor,
    output hsl_pkg::t_mem_ctl          o_ctl,
    output logic [BW-1:0]              o_bucket,
    output logic [WW-1:0]              o_way,
    output logic [FW-1:0]              o_fill_wdata,
    output logic [hsl_pkg::SIG_W-1:0]  o_key,
    output logic [hsl_pkg::NODE_W-1:0] o_node,
    output logic                       busy,
    output logic                       o_done,
    output hsl_pkg::t_rsp              o_rsp
);

    hsl_pkg::t_state r_state, n_state;

    logic [hsl_pkg::CFG_W-1:0]  r_bucket_count;
    logic                       r_func;
    logic [hsl_pkg::SIG_W-1:0]  r_sig;
    logic [hsl_pkg::NODE_W-1:0] r_node;
    logic [BW-1:0]              r_bucket, n_bucket;
    logic [FW-1:0]              r_way, n_way;
    logic                       r_hit, n_hit;
    logic                       r_done, n_done;
    hsl_pkg::t_rsp              r_rsp, n_rsp;

    logic                       accept;
    logic [hsl_pkg::CFG_W-1:0]  eff_count;

    assign accept = (r_state == hsl_pkg::S_IDLE) && start;

    // Saturate the bucket count into 1..BUCKETS.
    always_comb begin
        eff_count = r_bucket_count;
        if (r_bucket_count == '0) begin
            eff_count = hsl_pkg::CFG_W'(1);
        end else if (32'(r_bucket_count) > BUCKETS) begin
            eff_count = hsl_pkg::CFG_W'(BUCKETS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= hsl_pkg::S_CLEAR;
            r_bucket_count <= hsl_pkg::BUCKET_COUNT_RST;
            r_bucket       <= '0;
            r_way          <= '0;
            r_hit          <= 1'b0;
            r_done         <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bucket <= n_bucket;
            r_way    <= n_way;
            r_hit    <= n_hit;
            r_done   <= n_done;
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (accept) begin
            r_func <= i_req.func;
            r_sig  <= i_req.signature;
            r_node <= i_req.node_value;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_bucket     = r_bucket;
        n_way        = r_way;
        n_hit        = r_hit;
        n_done       = 1'b0;
        n_rsp        = r_rsp;
        o_ctl        = '0;
        o_fill_wdata = '0;

        unique case (r_state)
            hsl_pkg::S_CLEAR: begin
                // Sweep every bucket fill count to zero.
                o_ctl.fill_we = 1'b1;
                n_bucket      = r_bucket + 1'b1;
                if (r_bucket == BW'(BUCKETS - 1)) begin
                    n_state  = hsl_pkg::S_IDLE;
                    n_bucket = '0;
                end
            end
            hsl_pkg::S_IDLE: begin
                if (start) begin
                    n_state = hsl_pkg::S_DIV;
                end
            end
            hsl_pkg::S_DIV: begin
                if (i_div_done) begin
                    n_bucket = BW'(i_div_rem);
                    n_way    = '0;
                    n_hit    = 1'b0;
                    n_state  = hsl_pkg::S_FILL;
                end
            end
            hsl_pkg::S_FILL: begin
                n_state = hsl_pkg::S_KEY;
            end
            hsl_pkg::S_KEY: begin
                if (r_way == i_fill) begin
                    n_state = hsl_pkg::S_FINISH;
                end else begin
                    n_state = hsl_pkg::S_CMP;
                end
            end
            hsl_pkg::S_CMP: begin
                if (i_key == r_sig) begin
                    n_hit   = 1'b1;
                    n_state = hsl_pkg::S_FINISH;
                end else begin
                    n_way   = r_way + 1'b1;
                    n_state = hsl_pkg::S_KEY;
                end
            end
            hsl_pkg::S_FINISH: begin
                n_done            = 1'b1;
                n_state           = hsl_pkg::S_IDLE;
                n_rsp.found_value = hsl_pkg::NO_VALUE;
                if (r_func == hsl_pkg::FUNC_FIND) begin
                    if (r_hit) begin
                        n_rsp.status      = hsl_pkg::ST_FOUND;
                        n_rsp.found_value = {1'b0, i_node};
                    end else begin
                        n_rsp.status = hsl_pkg::ST_NOTFOUND;
                    end
                end else if (r_hit) begin
                    n_rsp.status = hsl_pkg::ST_DUPLICATE;
                end else if (i_fill == FW'(WAYS)) begin
                    n_rsp.status = hsl_pkg::ST_FULL;
                end else begin
                    // Append at the first free way; r_way equals the fill here.
                    n_rsp.status  = hsl_pkg::ST_INSERTED;
                    o_ctl.ent_we  = 1'b1;
                    o_ctl.fill_we = 1'b1;
                    o_fill_wdata  = i_fill + 1'b1;
                end
            end
            default: begin
                n_state = hsl_pkg::S_IDLE;
            end
        endcase
    end

    assign o_div_start = accept;
    assign o_divisor   = eff_count;
    assign o_bucket    = r_bucket;
    assign o_way       = r_way[WW-1:0];
    assign o_key       = r_sig;
    assign o_node      = r_node;
    assign busy        = (r_state != hsl_pkg::S_IDLE);
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

endmodule

FILE: design/hashed_signature_lookup_table.sv
// ----------------------------------------------------------------------------
// hashed_signature_lookup_table
// Signature to node-index hash table with fixed-way buckets.
// ----------------------------------------------------------------------------
// Usage: raise start with a request on i_req while busy is low; the request
// is taken at that edge and busy stays high until the result goes out. Each
// request yields exactly one result, shown on o_rsp for a single cycle with
// o_done high; the receiver cannot stall, so capture it in that cycle. A
// request passes through a 64-step serial remainder of the signature by the
// bucket count, then a scan of the filled ways of its bucket (at most WAYS)
// that stops at the first match; the remainder takes most of its time, and
// each scanned way costs one memory read and one compare. After reset the
// block sweeps the bucket fill counts to zero, one bucket per cycle, with
// busy high; configuration writes are taken during that sweep. Write
// i_cfg_wdata with i_cfg_we only while no request is in flight.
// ----------------------------------------------------------------------------
module hashed_signature_lookup_table #(
    parameter int BUCKETS = hsl_pkg::BUCKETS_DEF,
    parameter int WAYS    = hsl_pkg::WAYS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      start,
    input  hsl_pkg::t_req             i_req,
    output logic                      busy,
    // result channel
    output logic                      o_done,
    output hsl_pkg::t_rsp             o_rsp,
    // bucket count register
    input  logic                      i_cfg_we,
    input  logic [hsl_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW = $clog2(WAYS + 1);

    // Remainder unit handshake.
    logic                       div_start;
    logic                       div_done;
    logic [hsl_pkg::CFG_W-1:0]  divisor;
    logic [hsl_pkg::CFG_W-1:0]  div_rem;

    // Table access from the sequencer.
    hsl_pkg::t_mem_ctl          mem_ctl;
    logic [BW-1:0]              bucket;
    logic [WW-1:0]              way;
    logic [FW-1:0]              fill_wdata;
    logic [hsl_pkg::SIG_W-1:0]  wr_key;
    logic [hsl_pkg::NODE_W-1:0] wr_node;
    logic [FW-1:0]              rd_fill;
    logic [hsl_pkg::SIG_W-1:0]  rd_key;
    logic [hsl_pkg::NODE_W-1:0] rd_node;

    // Bucket index: signature modulo the saturated bucket count, one bit a
    // cycle. Latch the signature straight from the port at acceptance.
    hsl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.signature),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Fill counts and entries; address an entry as {bucket, way}.
    hsl_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_table (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_bucket     (bucket),
        .i_way        (way),
        .i_fill_wdata (fill_wdata),
        .i_key        (wr_key),
        .i_node       (wr_node),
        .o_fill       (rd_fill),
        .o_key        (rd_key),
        .o_node       (rd_node)
    );

    // Sequencer: clear sweep, remainder, scan of the bucket's ways in
    // insertion order, then the update and the one-cycle result.
    hsl_ctrl #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_div_done   (div_done),
        .i_div_rem    (div_rem),
        .i_fill       (rd_fill),
        .i_key        (rd_key),
        .i_node       (rd_node),
        .o_div_start  (div_start),
        .o_divisor    (divisor),
        .o_ctl        (mem_ctl),
        .o_bucket     (bucket),
        .o_way        (way),
        .o_fill_wdata (fill_wdata),
        .o_key        (wr_key),
        .o_node       (wr_node),
        .busy         (busy),
        .o_done       (o_done),
        .o_rsp        (o_rsp)
    );

endmodule

FILE: design/hsl_checker.sv
// ----------------------------------------------------------------------------
// hsl_checker
// Port-level checks of the lookup table's request and result behavior.
// ----------------------------------------------------------------------------
`include "hashed_signature_lookup_table_assert.svh"

module hsl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input hsl_pkg::t_rsp o_rsp
);

    // A taken request keeps the block busy through the next cycle.
    `HSL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)

    // Results never come back to back: each needs a full remainder pass.
    `HSL_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)

    // Anything but a hit reports no node index.
    `HSL_ASSERT_NOW(a_no_value, i_clk, i_rst_n, o_done && (o_rsp.status != hsl_pkg::ST_FOUND), o_rsp.found_value == hsl_pkg::NO_VALUE)

    // A hit returns a stored 31-bit index, never a negative value.
    `HSL_ASSERT_NOW(a_found_pos, i_clk, i_rst_n, o_done && (o_rsp.status == hsl_pkg::ST_FOUND), !o_rsp.found_value[31])

endmodule

bind hashed_signature_lookup_table hsl_checker u_hsl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
